>>> design/hq_pkg.sv
// shared types and constants for the timestamp/node id min-heap queue
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package hq_pkg;

  localparam int DEPTH   = 32;
  localparam int STAMP_W = 32;
  localparam int NODE_W  = 8;
  localparam int PAY_W   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_EXTRACT = 1'b1;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_EXTRACTED = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [PAY_W-1:0]   pay;
    logic [STAMP_W-1:0] stamp;
    logic [NODE_W-1:0]  node;
  } entry_t;

  typedef struct packed {
    logic             valid;
    logic [1:0]       status;
    entry_t           data;
    logic [CNT_W-1:0] count;
  } res_t;

endpackage

>>> design/timestamp_id_min_heap_queue_unit.sv
// top level of the timestamp/node id min-heap queue with its output register
// depends on hq_pkg and hq_ctrl
`timescale 1ns / 1ps

// Holds up to 32 entries ordered by stamp, then node id; extract returns the
// smallest. One item is worked on at a time: in_ready_o is high only while
// the sequencer is idle, and the result sits in an output register so the
// next item can be taken while it waits. An insert writes the entry at the
// end and lets it rise toward the root; an extract takes the root, moves the
// last entry to the root and lets it sink. Each sift step is paced by the one
// shared key comparator and the registered read of the entry memory. A full
// insert is dropped with status full; an empty extract reports status empty
// with zero data.
module timestamp_id_min_heap_queue_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       action_i,
  input  logic [hq_pkg::PAY_W-1:0]   payload_code_i,
  input  logic [hq_pkg::STAMP_W-1:0] stamp_i,
  input  logic [hq_pkg::NODE_W-1:0]  node_id_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [hq_pkg::PAY_W-1:0]   out_payload_code_o,
  output logic [hq_pkg::STAMP_W-1:0] out_stamp_o,
  output logic [hq_pkg::NODE_W-1:0]  out_node_id_o,
  output logic [hq_pkg::CNT_W-1:0]   count_o
);
  import hq_pkg::*;

  entry_t in_entry;
  res_t   res;
  logic   res_ready;

  logic             out_valid_q, out_valid_d;
  logic [1:0]       status_q;
  entry_t           data_q;
  logic [CNT_W-1:0] count_q;

  assign in_entry.pay   = payload_code_i;
  assign in_entry.stamp = stamp_i;
  assign in_entry.node  = node_id_i;

  hq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .in_entry_i  (in_entry),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      status_q <= res.status;
      data_q   <= res.data;
      count_q  <= res.count;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign out_payload_code_o = data_q.pay;
  assign out_stamp_o        = data_q.stamp;
  assign out_node_id_o      = data_q.node;
  assign count_o            = count_q;

endmodule

>>> design/hq_cmp.sv
// shared key comparator: stamp first, node id second
// depends on hq_pkg
`timescale 1ns / 1ps

module hq_cmp (
  input  hq_pkg::entry_t a_i,
  input  hq_pkg::entry_t b_i,
  output logic           a_less_o
);
  import hq_pkg::*;

  always_comb begin
    if (a_i.stamp != b_i.stamp) begin
      a_less_o = (a_i.stamp < b_i.stamp);
    end else begin
      a_less_o = (a_i.node < b_i.node);
    end
  end

endmodule

>>> design/hq_ctrl.sv
// heap sequencer: entry memory, entry count and sift up/down steps
// depends on hq_pkg and hq_cmp
`timescale 1ns / 1ps

module hq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  hq_pkg::entry_t     in_entry_i,
  output hq_pkg::res_t       res_o,
  input  logic               res_ready_i
);
  import hq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP_RD  = 3'd1;
  localparam logic [2:0] S_UP_CMP = 3'd2;
  localparam logic [2:0] S_EX_LD  = 3'd3;
  localparam logic [2:0] S_DN_RD  = 3'd4;
  localparam logic [2:0] S_DN_CR  = 3'd5;
  localparam logic [2:0] S_DN_CC  = 3'd6;
  localparam logic [2:0] S_RES    = 3'd7;

  localparam int CW = IDX_W + 2;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [IDX_W-1:0] cand_idx_q, cand_idx_d;
  entry_t           cur_q, cur_d;
  entry_t           cand_q, cand_d;
  entry_t           res_data_q, res_data_d;
  logic [1:0]       res_st_q, res_st_d;

  entry_t           mem [DEPTH];
  entry_t           rdata0_q, rdata1_q;
  logic             we;
  logic [IDX_W-1:0] waddr, raddr0, raddr1;
  entry_t           wdata;

  entry_t           cmp_a, cmp_b;
  logic             a_less;

  logic [IDX_W-1:0] parent_idx;
  logic [CW-1:0]    lc, rc, cnt_ext;

  hq_cmp u_cmp (
    .a_i      (cmp_a),
    .b_i      (cmp_b),
    .a_less_o (a_less)
  );

  assign parent_idx = IDX_W'((pos_q - IDX_W'(1)) >> 1);
  assign lc         = {1'b0, pos_q, 1'b1};
  assign rc         = lc + CW'(1);
  assign cnt_ext    = CW'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0_q <= mem[raddr0];
    rdata1_q <= mem[raddr1];
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    cand_idx_d = cand_idx_q;
    cur_d      = cur_q;
    cand_d     = cand_q;
    res_data_d = res_data_q;
    res_st_d   = res_st_q;
    we         = 1'b0;
    waddr      = pos_q;
    wdata      = cur_q;
    raddr0     = parent_idx;
    raddr1     = parent_idx;
    cmp_a      = cur_q;
    cmp_b      = rdata0_q;
    in_ready_o = 1'b0;
    res_o      = '0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_data_d = '0;
          if (action_i == ACT_INSERT) begin
            if (cnt_q == CNT_W'(DEPTH)) begin
              res_st_d = ST_FULL;
              state_d  = S_RES;
            end else begin
              res_st_d = ST_INSERTED;
              cur_d    = in_entry_i;
              pos_d    = cnt_q[IDX_W-1:0];
              cnt_d    = cnt_q + CNT_W'(1);
              state_d  = S_UP_RD;
            end
          end else begin
            if (cnt_q == '0) begin
              res_st_d = ST_EMPTY;
              state_d  = S_RES;
            end else begin
              res_st_d = ST_EXTRACTED;
              raddr0   = '0;
              raddr1   = IDX_W'(cnt_q - CNT_W'(1));
              cnt_d    = cnt_q - CNT_W'(1);
              state_d  = S_EX_LD;
            end
          end
        end
      end
      S_UP_RD: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          state_d = S_RES;
        end else begin
          raddr0  = parent_idx;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmp_a = cur_q;
        cmp_b = rdata0_q;
        we    = 1'b1;
        if (a_less) begin
          // parent moves down into the hole
          wdata   = rdata0_q;
          pos_d   = parent_idx;
          state_d = S_UP_RD;
        end else begin
          state_d = S_RES;
        end
      end
      S_EX_LD: begin
        res_data_d = rdata0_q;
        cur_d      = rdata1_q;
        pos_d      = '0;
        state_d    = (cnt_q == '0) ? S_RES : S_DN_RD;
      end
      S_DN_RD: begin
        if (lc >= cnt_ext) begin
          we      = 1'b1;
          state_d = S_RES;
        end else begin
          raddr0  = lc[IDX_W-1:0];
          raddr1  = (rc < cnt_ext) ? rc[IDX_W-1:0] : lc[IDX_W-1:0];
          state_d = S_DN_CR;
        end
      end
      S_DN_CR: begin
        // right child wins only when strictly smaller
        cmp_a = rdata1_q;
        cmp_b = rdata0_q;
        if ((rc < cnt_ext) && a_less) begin
          cand_d     = rdata1_q;
          cand_idx_d = rc[IDX_W-1:0];
        end else begin
          cand_d     = rdata0_q;
          cand_idx_d = lc[IDX_W-1:0];
        end
        state_d = S_DN_CC;
      end
      S_DN_CC: begin
        cmp_a = cand_q;
        cmp_b = cur_q;
        we    = 1'b1;
        if (a_less) begin
          wdata   = cand_q;
          pos_d   = cand_idx_q;
          state_d = S_DN_RD;
        end else begin
          state_d = S_RES;
        end
      end
      S_RES: begin
        res_o.valid  = 1'b1;
        res_o.status = res_st_q;
        res_o.data   = res_data_q;
        res_o.count  = cnt_q;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    cand_idx_q <= cand_idx_d;
    cur_q      <= cur_d;
    cand_q     <= cand_d;
    res_data_q <= res_data_d;
    res_st_q   <= res_st_d;
  end

endmodule

>>> design/hq_chk.sv
// port-level checker for the min-heap queue and its bind to the top level
// depends on hq_pkg and timestamp_id_min_heap_queue_unit
`timescale 1ns / 1ps

module hq_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       action_i,
  input logic [hq_pkg::PAY_W-1:0]   payload_code_i,
  input logic [hq_pkg::STAMP_W-1:0] stamp_i,
  input logic [hq_pkg::NODE_W-1:0]  node_id_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [1:0]                 status_o,
  input logic [hq_pkg::PAY_W-1:0]   out_payload_code_o,
  input logic [hq_pkg::STAMP_W-1:0] out_stamp_o,
  input logic [hq_pkg::NODE_W-1:0]  out_node_id_o,
  input logic [hq_pkg::CNT_W-1:0]   count_o
);
  import hq_pkg::*;

  // a stalled result item holds its status, count and stamp
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(count_o)
      && $stable(out_stamp_o))
    else $error("stalled result changed");

  // only extracted items carry data
  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_EXTRACTED) |->
      (out_payload_code_o == '0) && (out_stamp_o == '0) && (out_node_id_o == '0))
    else $error("nonzero data on non-extract result");

  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> (count_o == '0))
    else $error("empty result with nonzero count");

  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> (count_o == CNT_W'(DEPTH)))
    else $error("full result without full count");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o <= CNT_W'(DEPTH)))
    else $error("count beyond depth");

endmodule

bind timestamp_id_min_heap_queue_unit hq_chk u_hq_chk (.*);

>>> tb/timestamp_id_min_heap_queue_unit_tb.sv
// self-checking testbench for the timestamp/node id min-heap queue
// checks every result against an in-bench heap predictor or a directed expected result; depends on hq_pkg
`timescale 1ns / 1ps

module timestamp_id_min_heap_queue_unit_tb;
  import hq_pkg::*;

  localparam int ITEM_TARGET    = 1400;
  localparam int QUIET_FROM     = 1250;
  localparam int PRESSURE_AT    = 600;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 40;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [1:0]       status;
    entry_t           data;
    logic [CNT_W-1:0] count;
  } heap_result_t;

  typedef struct packed {
    logic         act;
    entry_t       data;
    logic         typed;
    heap_result_t want;
  } dir_row_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               action_i;
  logic [PAY_W-1:0]   payload_code_i;
  logic [STAMP_W-1:0] stamp_i;
  logic [NODE_W-1:0]  node_id_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         status_o;
  logic [PAY_W-1:0]   out_payload_code_o;
  logic [STAMP_W-1:0] out_stamp_o;
  logic [NODE_W-1:0]  out_node_id_o;
  logic [CNT_W-1:0]   count_o;

  timestamp_id_min_heap_queue_unit u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .action_i           (action_i),
    .payload_code_i     (payload_code_i),
    .stamp_i            (stamp_i),
    .node_id_i          (node_id_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .out_payload_code_o (out_payload_code_o),
    .out_stamp_o        (out_stamp_o),
    .out_node_id_o      (out_node_id_o),
    .count_o            (count_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predicted heap contents
  entry_t heap_mem [DEPTH];
  int     model_fill = 0;
  int     heap_peak = 0;

  heap_result_t pending_results [$];
  dir_row_t     directed_rows [$];

  logic         cur_typed = 1'b0;
  heap_result_t cur_want = '0;
  heap_result_t predicted, got, want;

  int gap_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int error_count = 0;
  int idle_cycles = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  function automatic bit key_before(entry_t a, entry_t b);
    if (a.stamp != b.stamp) return a.stamp < b.stamp;
    return a.node < b.node;
  endfunction

  function automatic heap_result_t heap_step(logic act, entry_t item);
    heap_result_t r;
    entry_t       tmp;
    int           pos, up, left, best;
    r = '0;
    if (act == ACT_INSERT) begin
      if (model_fill >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = model_fill;
        heap_mem[pos] = item;
        model_fill++;
        while (pos != 0) begin
          up = (pos - 1) / 2;
          if (!key_before(heap_mem[pos], heap_mem[up])) break;
          tmp = heap_mem[pos];
          heap_mem[pos] = heap_mem[up];
          heap_mem[up] = tmp;
          pos = up;
        end
        r.status = ST_INSERTED;
      end
    end else if (model_fill == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.data = heap_mem[0];
      model_fill--;
      if (model_fill > 0) begin
        heap_mem[0] = heap_mem[model_fill];
        pos = 0;
        forever begin
          left = 2 * pos + 1;
          best = pos;
          // strict compare keeps the parent on a tie and the left child on a tie
          if (left < model_fill && key_before(heap_mem[left], heap_mem[best])) best = left;
          if (left + 1 < model_fill && key_before(heap_mem[left + 1], heap_mem[best]))
            best = left + 1;
          if (best == pos) break;
          tmp = heap_mem[pos];
          heap_mem[pos] = heap_mem[best];
          heap_mem[best] = tmp;
          pos = best;
        end
      end
      r.status = ST_EXTRACTED;
    end
    r.count = CNT_W'(model_fill);
    return r;
  endfunction

  // scoreboard: predict on every accepted item, check on every accepted result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predicted = heap_step(action_i, {payload_code_i, stamp_i, node_id_i});
        if (model_fill > heap_peak) heap_peak = model_fill;
        pending_results.push_back(cur_typed ? cur_want : predicted);
      end
      if (out_valid_o && out_ready_i) begin
        got = {status_o, out_payload_code_o, out_stamp_o, out_node_id_o, count_o};
        status_seen[got.status]++;
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: result with nothing pending: status %0d count %0d", $time,
                     got.status, got.count);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status || got.data.pay !== want.data.pay ||
              got.data.stamp !== want.data.stamp || got.data.node !== want.data.node ||
              got.count !== want.count) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("%0t: exp st %0d pay %h stamp %h node %h cnt %0d",
                       $time, want.status, want.data.pay, want.data.stamp, want.data.node,
                       want.count);
              $display("%0t: got st %0d pay %h stamp %h node %h cnt %0d",
                       $time, got.status, got.data.pay, got.data.stamp, got.data.node,
                       got.count);
            end
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random stall bursts
  always begin
    @(negedge clk_i);
    if (rst_ni && $urandom_range(0, 99) < stall_pct) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    out_ready_i <= 1'b1;
  end

  // called and returns at a falling edge
  task automatic drive_item(logic act, entry_t e, logic typed, heap_result_t w);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    cur_typed = typed;
    cur_want  = w;
    in_valid_i     <= 1'b1;
    action_i       <= act;
    payload_code_i <= e.pay;
    stamp_i        <= e.stamp;
    node_id_i      <= e.node;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic dir_row(logic act, logic [PAY_W-1:0] pay, logic [STAMP_W-1:0] stamp,
                         logic [NODE_W-1:0] node, logic typed, logic [1:0] st,
                         int cnt, logic [PAY_W-1:0] opay, logic [STAMP_W-1:0] ostamp,
                         logic [NODE_W-1:0] onode);
    dir_row_t r;
    r.act   = act;
    r.data  = {pay, stamp, node};
    r.typed = typed;
    r.want  = {st, opay, ostamp, onode, CNT_W'(cnt)};
    directed_rows.push_back(r);
  endtask

  // keys cluster so that ties in stamp and in node id come up often
  function automatic entry_t rand_entry();
    entry_t e;
    e.pay = PAY_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0: e.stamp = STAMP_W'($urandom_range(0, 7));
      1: e.stamp = STAMP_W'($urandom());
      2: e.stamp = $urandom_range(0, 1) ? '1 : '0;
      default: e.stamp = {{(STAMP_W - 3){1'b1}}, 3'($urandom_range(0, 7))};
    endcase
    case ($urandom_range(0, 2))
      0: e.node = NODE_W'($urandom_range(0, 3));
      1: e.node = NODE_W'($urandom_range(0, 255));
      default: e.node = $urandom_range(0, 1) ? '1 : '0;
    endcase
    return e;
  endfunction

  initial begin
    phase_e kind;
    int     phase;
    int     n;
    int     ins_pct;
    bit     pressure_done;
    logic   act;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    action_i       = ACT_INSERT;
    payload_code_i = '0;
    stamp_i        = '0;
    node_id_i      = '0;
    phase          = 0;
    pressure_done  = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    dir_row(ACT_EXTRACT, 16'h0000, 32'h0000_0000, 8'h00, 1, ST_EMPTY, 0, 0, 0, 0);
    dir_row(ACT_INSERT, 16'hffff, 32'hffff_ffff, 8'hff, 1, ST_INSERTED, 1, 0, 0, 0);
    dir_row(ACT_INSERT, 16'h0000, 32'h0000_0000, 8'h00, 1, ST_INSERTED, 2, 0, 0, 0);
    dir_row(ACT_INSERT, 16'h1234, 32'h0000_0000, 8'hff, 1, ST_INSERTED, 3, 0, 0, 0);
    // same key as an entry already held
    dir_row(ACT_INSERT, 16'h5555, 32'h0000_0000, 8'h00, 1, ST_INSERTED, 4, 0, 0, 0);
    dir_row(ACT_INSERT, 16'haaaa, 32'hffff_ffff, 8'h00, 1, ST_INSERTED, 5, 0, 0, 0);
    dir_row(ACT_INSERT, 16'h8000, 32'h8000_0000, 8'h80, 1, ST_INSERTED, 6, 0, 0, 0);
    dir_row(ACT_INSERT, 16'h7fff, 32'h7fff_ffff, 8'h7f, 1, ST_INSERTED, 7, 0, 0, 0);
    dir_row(ACT_INSERT, 16'h0001, 32'h0000_0000, 8'h00, 1, ST_INSERTED, 8, 0, 0, 0);
    repeat (7) dir_row(ACT_EXTRACT, 16'h0, 32'h0, 8'h0, 0, ST_EXTRACTED, 0, 0, 0, 0);
    dir_row(ACT_EXTRACT, 16'h0000, 32'h0000_0000, 8'h00, 1, ST_EXTRACTED, 0,
            16'hffff, 32'hffff_ffff, 8'hff);
    dir_row(ACT_EXTRACT, 16'hffff, 32'hffff_ffff, 8'hff, 1, ST_EMPTY, 0, 0, 0, 0);
    dir_row(ACT_INSERT, 16'hbeef, 32'h0000_0005, 8'h03, 1, ST_INSERTED, 1, 0, 0, 0);
    dir_row(ACT_EXTRACT, 16'h0000, 32'h0000_0000, 8'h00, 1, ST_EXTRACTED, 0,
            16'hbeef, 32'h0000_0005, 8'h03);

    gap_pct   = 20;
    stall_pct = 10;
    foreach (directed_rows[i])
      drive_item(directed_rows[i].act, directed_rows[i].data, directed_rows[i].typed,
                 directed_rows[i].want);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= QUIET_FROM) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(0, 3) * 20;
        stall_pct = $urandom_range(0, 3) * 8;
      end
      // open with a full fill and a full drain, then pick at random
      case (phase < 2 ? phase : $urandom_range(0, 3))
        0: kind = PH_FILL;
        1: kind = PH_DRAIN;
        default: kind = PH_MIXED;
      endcase
      case (kind)
        PH_FILL: begin
          while (model_fill < DEPTH) drive_item(ACT_INSERT, rand_entry(), 1'b0, '0);
          repeat ($urandom_range(1, 3)) drive_item(ACT_INSERT, rand_entry(), 1'b0, '0);
        end
        PH_DRAIN: begin
          while (model_fill > 0) drive_item(ACT_EXTRACT, rand_entry(), 1'b0, '0);
          repeat ($urandom_range(1, 3)) drive_item(ACT_EXTRACT, rand_entry(), 1'b0, '0);
        end
        default: begin
          n       = $urandom_range(20, 60);
          ins_pct = $urandom_range(30, 70);
          repeat (n) begin
            act = ($urandom_range(0, 99) < ins_pct) ? ACT_INSERT : ACT_EXTRACT;
            drive_item(act, rand_entry(), 1'b0, '0);
          end
        end
      endcase
      if (!pressure_done && items_sent >= PRESSURE_AT) begin
        wait_all_results();
        pressure_done = 1'b1;
      end
      phase++;
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    error_count += pending_results.size();

    $display("ran %0d items: %0d inserted, %0d extracted, %0d dropped on full, %0d on empty",
             items_sent, status_seen[ST_INSERTED], status_seen[ST_EXTRACTED],
             status_seen[ST_FULL], status_seen[ST_EMPTY]);
    $display("peak occupancy %0d of %0d, %0d errors", heap_peak, DEPTH, error_count);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
design/hq_pkg.sv
design/hq_cmp.sv
design/hq_ctrl.sv
design/timestamp_id_min_heap_queue_unit.sv
design/hq_chk.sv
tb/timestamp_id_min_heap_queue_unit_tb.sv
